// ----- sv/expvar_pkg.sv -----
// shared types, widths and constants of the exponential variogram evaluator
`default_nettype none

package expvar_pkg;

    // fixed-point fraction bits of coordinates, levels and range
    localparam int FRAC_BITS = 16;

    localparam int COORD_W   = 32;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int ROOT_W    = SQ_W / 2;
    localparam int REM_W     = ROOT_W + 1;
    localparam int SQRT_CELLS = ROOT_W;

    // decay argument t is only of interest below 64 << FRAC_BITS
    localparam int TQ_W      = 6 + FRAC_BITS;
    localparam int H3_W      = ROOT_W + 2;
    localparam int NUM_W     = H3_W + FRAC_BITS;
    localparam int NUM_TOP_W = NUM_W - TQ_W;
    localparam int DIV_W     = 32;

    localparam int TT_W      = TQ_W + 32 - FRAC_BITS;
    localparam int K_W       = 7;
    localparam int K_ZERO    = 33;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    localparam int E_W       = 33;
    localparam int N_TERMS   = 24;
    localparam int CNT_W     = 5;
    localparam int SERIES_CELLS = N_TERMS - 1;

    typedef enum logic [1:0] {
        REG_NUGGET = 2'd0,
        REG_SILL   = 2'd1,
        REG_RANGE  = 2'd2
    } cfg_reg_t;

    // control that travels alongside each item through the cell row
    typedef struct packed {
        logic           valid;
        logic           hzero;
        logic           ezero;
        logic [K_W-1:0] k;
    } tag_t;

    // floor(2^32 / n), a slight underestimate corrected after the product
    function automatic logic [31:0] recip_of(input logic [CNT_W-1:0] n);
        logic [31:0] m;
        case (n)
            5'd2:    m = 32'd2147483648;
            5'd3:    m = 32'd1431655765;
            5'd4:    m = 32'd1073741824;
            5'd5:    m = 32'd858993459;
            5'd6:    m = 32'd715827882;
            5'd7:    m = 32'd613566756;
            5'd8:    m = 32'd536870912;
            5'd9:    m = 32'd477218588;
            5'd10:   m = 32'd429496729;
            5'd11:   m = 32'd390451572;
            5'd12:   m = 32'd357913941;
            5'd13:   m = 32'd330382099;
            5'd14:   m = 32'd306783378;
            5'd15:   m = 32'd286331153;
            5'd16:   m = 32'd268435456;
            5'd17:   m = 32'd252645135;
            5'd18:   m = 32'd238609294;
            5'd19:   m = 32'd226050910;
            5'd20:   m = 32'd214748364;
            5'd21:   m = 32'd204522252;
            5'd22:   m = 32'd195225786;
            5'd23:   m = 32'd186737708;
            5'd24:   m = 32'd178956970;
            default: m = 32'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- sv/expvar_sqrt_cell.sv -----
// one digit step of the restoring square root row
`default_nettype none

module expvar_sqrt_cell (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            adv,
    input  expvar_pkg::tag_t               tag_in,
    input  wire [expvar_pkg::REM_W-1:0]    rem_in,
    input  wire [expvar_pkg::ROOT_W-1:0]   root_in,
    input  wire [expvar_pkg::SQ_W-1:0]     sq_in,
    output expvar_pkg::tag_t               tag_out,
    output logic [expvar_pkg::REM_W-1:0]   rem_out,
    output logic [expvar_pkg::ROOT_W-1:0]  root_out,
    output logic [expvar_pkg::SQ_W-1:0]    sq_out
);

    expvar_pkg::tag_t                tag_reg;
    logic [expvar_pkg::REM_W-1:0]    rem_reg,  rem_next;
    logic [expvar_pkg::ROOT_W-1:0]   root_reg, root_next;
    logic [expvar_pkg::SQ_W-1:0]     sq_reg,   sq_next;
    logic [expvar_pkg::REM_W+1:0]    cur;
    logic [expvar_pkg::REM_W+1:0]    trial;
    logic                            ge;

    always_comb begin
        cur       = {rem_in, sq_in[expvar_pkg::SQ_W-1 -: 2]};
        trial     = {1'b0, root_in, 2'b01};
        ge        = (cur >= trial);
        rem_next  = ge ? expvar_pkg::REM_W'(cur - trial) : expvar_pkg::REM_W'(cur);
        root_next = {root_in[expvar_pkg::ROOT_W-2:0], ge};
        sq_next   = {sq_in[expvar_pkg::SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (adv) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            sq_reg   <= sq_next;
        end
    end

    assign tag_out  = tag_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign sq_out   = sq_reg;

endmodule

`default_nettype wire

// ----- sv/expvar_div_cell.sv -----
// one quotient bit of the restoring divider row
`default_nettype none

module expvar_div_cell (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            adv,
    input  wire [expvar_pkg::DIV_W-1:0]    divisor,
    input  expvar_pkg::tag_t               tag_in,
    input  wire [expvar_pkg::DIV_W-1:0]    rem_in,
    input  wire [expvar_pkg::TQ_W-1:0]     nb_in,
    input  wire [expvar_pkg::TQ_W-1:0]     q_in,
    output expvar_pkg::tag_t               tag_out,
    output logic [expvar_pkg::DIV_W-1:0]   rem_out,
    output logic [expvar_pkg::TQ_W-1:0]    nb_out,
    output logic [expvar_pkg::TQ_W-1:0]    q_out
);

    expvar_pkg::tag_t               tag_reg;
    logic [expvar_pkg::DIV_W-1:0]   rem_reg, rem_next;
    logic [expvar_pkg::TQ_W-1:0]    nb_reg,  nb_next;
    logic [expvar_pkg::TQ_W-1:0]    q_reg,   q_next;
    logic [expvar_pkg::DIV_W:0]     cur;
    logic                           ge;

    always_comb begin
        cur      = {rem_in, nb_in[expvar_pkg::TQ_W-1]};
        ge       = (cur >= {1'b0, divisor});
        rem_next = ge ? expvar_pkg::DIV_W'(cur - {1'b0, divisor})
                      : expvar_pkg::DIV_W'(cur);
        nb_next  = {nb_in[expvar_pkg::TQ_W-2:0], 1'b0};
        q_next   = {q_in[expvar_pkg::TQ_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (adv) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg <= rem_next;
            nb_reg  <= nb_next;
            q_reg   <= q_next;
        end
    end

    assign tag_out = tag_reg;
    assign rem_out = rem_reg;
    assign nb_out  = nb_reg;
    assign q_out   = q_reg;

endmodule

`default_nettype wire

// ----- sv/expvar_series_cell.sv -----
// one term of the exp(-r) taylor series: term * r / 2^32 / n, then accumulate
`default_nettype none

module expvar_series_cell (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            adv,
    input  wire [expvar_pkg::CNT_W-1:0]    n_idx,
    input  expvar_pkg::tag_t               tag_in,
    input  wire [31:0]                     r_in,
    input  wire [31:0]                     term_in,
    input  wire [expvar_pkg::E_W-1:0]      e_in,
    output expvar_pkg::tag_t               tag_out,
    output logic [31:0]                    r_out,
    output logic [31:0]                    term_out,
    output logic [expvar_pkg::E_W-1:0]     e_out
);

    localparam int QN_W = 32 + expvar_pkg::CNT_W;

    // stage 1: term * r
    expvar_pkg::tag_t              tag1_reg;
    logic [63:0]                   prod1_reg;
    logic [31:0]                   r1_reg;
    logic [expvar_pkg::E_W-1:0]    e1_reg;
    // stage 2: reciprocal product
    expvar_pkg::tag_t              tag2_reg;
    logic [31:0]                   x2_reg;
    logic [63:0]                   xm2_reg;
    logic [31:0]                   r2_reg;
    logic [expvar_pkg::E_W-1:0]    e2_reg;
    // stage 3: corrected quotient and running sum
    expvar_pkg::tag_t              tag3_reg;
    logic [31:0]                   r3_reg;
    logic [31:0]                   term3_reg, term3_next;
    logic [expvar_pkg::E_W-1:0]    e3_reg,    e3_next;

    logic [31:0]                   q0;
    logic [QN_W-1:0]               back;
    logic [QN_W-1:0]               rem;

    always_comb begin
        q0   = xm2_reg[63:32];
        back = QN_W'({5'd0, q0} * {32'd0, n_idx});
        rem  = {5'd0, x2_reg} - back;
        term3_next = (rem >= QN_W'(n_idx)) ? q0 + 32'd1 : q0;
        if (n_idx[0]) begin
            e3_next = e2_reg - {1'b0, term3_next};
        end else begin
            e3_next = e2_reg + {1'b0, term3_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else if (adv) begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod1_reg <= {32'd0, term_in} * {32'd0, r_in};
            r1_reg    <= r_in;
            e1_reg    <= e_in;
            x2_reg    <= prod1_reg[63:32];
            xm2_reg   <= {32'd0, prod1_reg[63:32]} * {32'd0, expvar_pkg::recip_of(n_idx)};
            r2_reg    <= r1_reg;
            e2_reg    <= e1_reg;
            r3_reg    <= r2_reg;
            term3_reg <= term3_next;
            e3_reg    <= e3_next;
        end
    end

    assign tag_out  = tag3_reg;
    assign r_out    = r3_reg;
    assign term_out = term3_reg;
    assign e_out    = e3_reg;

endmodule

`default_nettype wire

// ----- sv/exponential_variogram_eval_top.sv -----
// top level of the exponential variogram evaluator: apb registers and the cell pipeline
`default_nettype none

// Exponential variogram evaluator. Each transaction on the s_ channel carries a pair of
// signed Q16.16 coordinate offsets; each m_ transaction returns the covariance
// (sill - nugget) * exp(-3h/range), or sill at zero lag, and the semivariance
// sill - that product, both saturated to signed 32 bits, where h = sqrt(dx^2 + dy^2).
// One transaction is taken every clock cycle while the row advances. From s_ acceptance
// to m_valid an item passes 3 stages of squaring and sum, 32 square-root cells,
// 2 scaling stages, 22 divider cells, 2 stages of reduction by ln 2, 23 series
// cells of 3 stages each, 3 stages of shift and product, and the output register.
// The whole row advances together; it halts only while a result sits unaccepted in the
// output register and the last stage holds another result. Registers (apb, byte
// address 4*i): nugget at 0x0, sill at 0x4, range at 0x8; write them only while idle.
module exponential_variogram_eval_top (
    input  wire         aclk,
    input  wire         aresetn,
    // apb configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input channel
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [31:0] s_offset_x,
    input  wire  [31:0] s_offset_y,
    // result channel
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_covariance_out,
    output logic [31:0] m_semivariance_out
);

    localparam int TQ_W  = expvar_pkg::TQ_W;
    localparam int TT_W  = expvar_pkg::TT_W;
    localparam int K_W   = expvar_pkg::K_W;
    localparam int E_W   = expvar_pkg::E_W;
    localparam int NSQ   = expvar_pkg::SQRT_CELLS;
    localparam int NSER  = expvar_pkg::SERIES_CELLS;
    localparam logic [TT_W-1:0] LN2_W = TT_W'(expvar_pkg::LN2_Q32);

    // ---------------------------------------------------------------- registers
    logic [31:0] nugget_reg;
    logic [31:0] sill_reg;
    logic [31:0] range_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nugget_reg <= 32'd13107;
            sill_reg   <= 32'd65536;
            range_reg  <= 32'd113512;
        end else if (cfg_write) begin
            case (expvar_pkg::cfg_reg_t'(paddr[3:2]))
                expvar_pkg::REG_NUGGET: nugget_reg <= pwdata;
                expvar_pkg::REG_SILL:   sill_reg   <= pwdata;
                expvar_pkg::REG_RANGE:  range_reg  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (expvar_pkg::cfg_reg_t'(paddr[3:2]))
            expvar_pkg::REG_NUGGET: prdata = nugget_reg;
            expvar_pkg::REG_SILL:   prdata = sill_reg;
            expvar_pkg::REG_RANGE:  prdata = range_reg;
            default:                prdata = 32'd0;
        endcase
    end

    // sill - nugget, exact in 33 bits, as sign and magnitude
    logic signed [32:0] dlev;
    logic               dneg;
    logic [32:0]        dabs;

    always_comb begin
        dlev = {sill_reg[31], sill_reg} - {nugget_reg[31], nugget_reg};
        dneg = dlev[32];
        dabs = dneg ? 33'(-dlev) : 33'(dlev);
    end

    // ---------------------------------------------------------------- flow control
    // every stage moves together; the output register parts the two channels
    logic             adv;
    expvar_pkg::tag_t j_tag_reg;
    logic             m_valid_reg, m_valid_next;

    assign adv     = !j_tag_reg.valid || !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ---------------------------------------------------------------- magnitudes and squares
    expvar_pkg::tag_t a_tag_reg, b_tag_reg, c_tag_reg;
    logic [31:0]      ax_reg, ay_reg;
    logic [63:0]      sqx_reg, sqy_reg, sq_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_tag_reg <= '0;
            b_tag_reg <= '0;
            c_tag_reg <= '0;
        end else if (adv) begin
            a_tag_reg <= '{valid: s_valid, hzero: 1'b0, ezero: 1'b0, k: '0};
            b_tag_reg <= a_tag_reg;
            c_tag_reg <= b_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg  <= s_offset_x[31] ? 32'(-s_offset_x) : s_offset_x;
            ay_reg  <= s_offset_y[31] ? 32'(-s_offset_y) : s_offset_y;
            sqx_reg <= {32'd0, ax_reg} * {32'd0, ax_reg};
            sqy_reg <= {32'd0, ay_reg} * {32'd0, ay_reg};
            sq_reg  <= sqx_reg + sqy_reg;
        end
    end

    // ---------------------------------------------------------------- square-root row
    expvar_pkg::tag_t                 sq_tag  [0:NSQ];
    logic [expvar_pkg::REM_W-1:0]     sq_rem  [0:NSQ];
    logic [expvar_pkg::ROOT_W-1:0]    sq_root [0:NSQ];
    logic [expvar_pkg::SQ_W-1:0]      sq_bits [0:NSQ];

    assign sq_tag[0]  = c_tag_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_bits[0] = sq_reg;

    for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
        expvar_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .tag_in   (sq_tag[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .sq_in    (sq_bits[i]),
            .tag_out  (sq_tag[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .sq_out   (sq_bits[i+1])
        );
    end

    // ---------------------------------------------------------------- scale lag to 3h << frac
    expvar_pkg::tag_t                 d_tag_reg, e_tag_reg;
    logic [expvar_pkg::H3_W-1:0]      h3_reg;
    logic [expvar_pkg::NUM_W-1:0]     num;
    logic [expvar_pkg::DIV_W-1:0]     e_rem_reg;
    logic [TQ_W-1:0]                  e_nb_reg;
    logic                             too_big;

    always_comb begin
        num     = {h3_reg, {expvar_pkg::FRAC_BITS{1'b0}}};
        // quotient would reach 64 << frac (or range is zero): decay is zero
        too_big = ({{(32 - expvar_pkg::NUM_TOP_W){1'b0}}, num[expvar_pkg::NUM_W-1:TQ_W]}
                   >= range_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_tag_reg <= '0;
            e_tag_reg <= '0;
        end else if (adv) begin
            d_tag_reg <= '{valid: sq_tag[NSQ].valid, hzero: (sq_root[NSQ] == '0),
                           ezero: sq_tag[NSQ].ezero, k: sq_tag[NSQ].k};
            e_tag_reg <= '{valid: d_tag_reg.valid, hzero: d_tag_reg.hzero,
                           ezero: too_big, k: d_tag_reg.k};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            h3_reg    <= {2'b00, sq_root[NSQ]} + {1'b0, sq_root[NSQ], 1'b0};
            e_rem_reg <= {{(32 - expvar_pkg::NUM_TOP_W){1'b0}},
                          num[expvar_pkg::NUM_W-1:TQ_W]};
            e_nb_reg  <= num[TQ_W-1:0];
        end
    end

    // ---------------------------------------------------------------- divider row, t = 3h / range
    expvar_pkg::tag_t                 dv_tag [0:TQ_W];
    logic [expvar_pkg::DIV_W-1:0]     dv_rem [0:TQ_W];
    logic [TQ_W-1:0]                  dv_nb  [0:TQ_W];
    logic [TQ_W-1:0]                  dv_q   [0:TQ_W];

    assign dv_tag[0] = e_tag_reg;
    assign dv_rem[0] = e_rem_reg;
    assign dv_nb[0]  = e_nb_reg;
    assign dv_q[0]   = '0;

    for (genvar i = 0; i < TQ_W; i++) begin : g_div
        expvar_div_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .divisor (range_reg),
            .tag_in  (dv_tag[i]),
            .rem_in  (dv_rem[i]),
            .nb_in   (dv_nb[i]),
            .q_in    (dv_q[i]),
            .tag_out (dv_tag[i+1]),
            .rem_out (dv_rem[i+1]),
            .nb_out  (dv_nb[i+1]),
            .q_out   (dv_q[i+1])
        );
    end

    // ---------------------------------------------------------------- t = k ln2 + r
    expvar_pkg::tag_t  g1_tag_reg, g2_tag_reg;
    logic [TT_W-1:0]   g1_rem_reg, g1_rem_next;
    logic [2:0]        g1_k_reg,   g1_k_next;
    logic [31:0]       g2_r_reg;
    logic [TT_W-1:0]   g2_rem_next;
    logic [K_W-1:0]    g2_k_next;
    logic [TT_W-1:0]   tt;

    // upper three quotient bits
    always_comb begin
        tt          = {dv_q[TQ_W], {(32 - expvar_pkg::FRAC_BITS){1'b0}}};
        g1_rem_next = tt;
        g1_k_next   = '0;
        for (int b = 2; b >= 0; b--) begin
            if (g1_rem_next >= (LN2_W << (b + 4))) begin
                g1_rem_next = g1_rem_next - (LN2_W << (b + 4));
                g1_k_next[b] = 1'b1;
            end
        end
    end

    // lower four quotient bits
    always_comb begin
        g2_rem_next = g1_rem_reg;
        g2_k_next   = {g1_k_reg, 4'b0000};
        for (int b = 3; b >= 0; b--) begin
            if (g2_rem_next >= (LN2_W << b)) begin
                g2_rem_next = g2_rem_next - (LN2_W << b);
                g2_k_next[b] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_tag_reg <= '0;
            g2_tag_reg <= '0;
        end else if (adv) begin
            g1_tag_reg <= dv_tag[TQ_W];
            g2_tag_reg <= '{valid: g1_tag_reg.valid, hzero: g1_tag_reg.hzero,
                            ezero: g1_tag_reg.ezero
                                   || (g2_k_next >= K_W'(expvar_pkg::K_ZERO)),
                            k: g2_k_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_rem_reg <= g1_rem_next;
            g1_k_reg   <= g1_k_next;
            g2_r_reg   <= g2_rem_next[31:0];
        end
    end

    // ---------------------------------------------------------------- series row, exp(-r)
    // first term is r itself; cells add terms two to twenty-four
    expvar_pkg::tag_t  se_tag  [0:NSER];
    logic [31:0]       se_r    [0:NSER];
    logic [31:0]       se_term [0:NSER];
    logic [E_W-1:0]    se_e    [0:NSER];

    assign se_tag[0]  = g2_tag_reg;
    assign se_r[0]    = g2_r_reg;
    assign se_term[0] = g2_r_reg;
    assign se_e[0]    = {1'b1, 32'd0} - {1'b0, g2_r_reg};

    for (genvar i = 0; i < NSER; i++) begin : g_series
        expvar_series_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .n_idx    (expvar_pkg::CNT_W'(i + 2)),
            .tag_in   (se_tag[i]),
            .r_in     (se_r[i]),
            .term_in  (se_term[i]),
            .e_in     (se_e[i]),
            .tag_out  (se_tag[i+1]),
            .r_out    (se_r[i+1]),
            .term_out (se_term[i+1]),
            .e_out    (se_e[i+1])
        );
    end

    // ---------------------------------------------------------------- decay and product
    expvar_pkg::tag_t  h_tag_reg, i_tag_reg;
    logic [E_W-1:0]    dec_reg;
    logic [E_W-1:0]    i_dec_reg;
    logic [63:0]       lo_prod_reg;
    logic [32:0]       mag_reg, mag_next;

    // |d| * E / 2^32 with the 2^32 bits of either factor folded in separately
    always_comb begin
        mag_next = 33'(lo_prod_reg[63:32])
                 + (dabs[32] ? i_dec_reg : 33'd0)
                 + (i_dec_reg[32] ? {1'b0, dabs[31:0]} : 33'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_tag_reg <= '0;
            i_tag_reg <= '0;
            j_tag_reg <= '0;
        end else if (adv) begin
            h_tag_reg <= se_tag[NSER];
            i_tag_reg <= h_tag_reg;
            j_tag_reg <= i_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dec_reg     <= se_tag[NSER].ezero ? '0 : (se_e[NSER] >> se_tag[NSER].k);
            i_dec_reg   <= dec_reg;
            lo_prod_reg <= {32'd0, dabs[31:0]} * {32'd0, dec_reg[31:0]};
            mag_reg     <= mag_next;
        end
    end

    // ---------------------------------------------------------------- output register
    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] s;
        if (v > 36'sd2147483647) begin
            s = 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            s = 32'h8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    logic signed [35:0] prod_s;
    logic signed [35:0] sill_s;
    logic [31:0]        cov_next, semi_next;
    logic [31:0]        cov_reg, semi_reg;

    always_comb begin
        prod_s    = dneg ? -$signed({3'b000, mag_reg}) : $signed({3'b000, mag_reg});
        sill_s    = 36'($signed(sill_reg));
        cov_next  = j_tag_reg.hzero ? sill_reg : sat32(prod_s);
        semi_next = sat32(sill_s - prod_s);
    end

    always_comb begin
        if (adv && j_tag_reg.valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && j_tag_reg.valid) begin
            cov_reg  <= cov_next;
            semi_reg <= semi_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_covariance_out   = cov_reg;
    assign m_semivariance_out = semi_reg;

endmodule

`default_nettype wire

// ----- tb/exponential_variogram_eval_checker.sv -----
// checker for the exponential variogram evaluator: predicts and compares every result
`default_nettype none

module exponential_variogram_eval_checker (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire         pready,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [31:0] s_offset_x,
    input  wire  [31:0] s_offset_y,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [31:0] m_covariance_out,
    input  wire  [31:0] m_semivariance_out,
    output int          error_count,
    output int          pending_count
);

    logic [31:0] nugget_q, sill_q, range_q;
    logic [63:0] lag_queue[$];

    function automatic logic [63:0] isqrt(input logic [63:0] s);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > s) bitv >>= 2;
        while (bitv != 0) begin
            if (s >= res + bitv) begin
                s = s - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // exp(-t) in Q32 for t in Q16
    function automatic logic [63:0] decay(input logic [63:0] t);
        logic [63:0] tt, k, r, e, term;
        logic [127:0] prod;
        if (t >= (64'd64 << expvar_pkg::FRAC_BITS)) return 0;
        tt = t << (32 - expvar_pkg::FRAC_BITS);
        k = tt / 64'(expvar_pkg::LN2_Q32);
        r = tt - k * 64'(expvar_pkg::LN2_Q32);
        e = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int n = 1; n <= expvar_pkg::N_TERMS; n++) begin
            prod = 128'(term) * 128'(r);
            term = 64'(prod >> 32) / 64'(n);
            if (n % 2 == 1) e = e - term;
            else e = e + term;
        end
        if (k >= expvar_pkg::K_ZERO) return 0;
        return e >> k;
    endfunction

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // predicted covariance in the upper half, semivariance in the lower
    function automatic logic [63:0] predict_lag(input logic [31:0] ox, input logic [31:0] oy);
        longint dx, dy, nug, sill, d, p;
        logic [63:0] ax, ay, h, e, t, mag;
        logic [127:0] prod;
        dx = longint'($signed(ox));
        dy = longint'($signed(oy));
        nug = longint'($signed(nugget_q));
        sill = longint'($signed(sill_q));
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        h = isqrt(ax * ax + ay * ay);
        if (range_q == 0) begin
            e = 0;
        end else begin
            t = ((64'd3 * h) << expvar_pkg::FRAC_BITS) / 64'(range_q);
            e = decay(t);
        end
        d = sill - nug;
        mag = d < 0 ? -d : d;
        prod = 128'(mag) * 128'(e);
        mag = 64'(prod >> 32);
        p = d < 0 ? -longint'(mag) : longint'(mag);
        return {(h == 0) ? clamp32(sill) : clamp32(p), clamp32(sill - p)};
    endfunction

    always @(posedge aclk) begin
        logic [63:0] want;
        int          bad;
        bad = 0;
        if (!aresetn) begin
            nugget_q <= 32'd13107;
            sill_q <= 32'd65536;
            range_q <= 32'd113512;
            error_count <= 0;
            pending_count <= 0;
            lag_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (expvar_pkg::cfg_reg_t'(paddr[3:2]))
                    expvar_pkg::REG_NUGGET: nugget_q <= pwdata;
                    expvar_pkg::REG_SILL:   sill_q <= pwdata;
                    expvar_pkg::REG_RANGE:  range_q <= pwdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) lag_queue.push_back(predict_lag(s_offset_x, s_offset_y));
            if (m_valid && m_ready) begin
                if (lag_queue.size() == 0) begin
                    $display("%0t: result with none expected, got cov %h semi %h",
                             $time, m_covariance_out, m_semivariance_out);
                    bad = bad + 1;
                end else begin
                    want = lag_queue.pop_front();
                    if (want[63:32] !== m_covariance_out) begin
                        $display("%0t: covariance expected %h actual %h",
                                 $time, want[63:32], m_covariance_out);
                        bad = bad + 1;
                    end
                    if (want[31:0] !== m_semivariance_out) begin
                        $display("%0t: semivariance expected %h actual %h",
                                 $time, want[31:0], m_semivariance_out);
                        bad = bad + 1;
                    end
                end
            end
            error_count <= error_count + bad;
            pending_count <= lag_queue.size();
        end
    end

endmodule

`default_nettype wire

// ----- tb/exponential_variogram_eval_top_tb.sv -----
// testbench top of the exponential variogram evaluator: stimulus, registers and verdict
`default_nettype none

module exponential_variogram_eval_top_tb;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    logic [31:0] s_offset_x = 0, s_offset_y = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_covariance_out, m_semivariance_out;
    int          error_count, pending_count;
    bit          quiet_stretch = 0;   // no idling on either side while set

    // latency of the cell row plus margin
    localparam int DRAIN_CYCLES = 200;

    always #4 aclk = ~aclk;

    exponential_variogram_eval_top dut (.*);

    exponential_variogram_eval_checker chk (.*);

    // result side stalls at random, about 6 percent of the time
    always @(posedge aclk) begin
        m_ready <= quiet_stretch || ($urandom_range(99) >= 6);
    end

    // one register write: setup phase, access phase, then rest with psel low
    task automatic write_reg(input expvar_pkg::cfg_reg_t idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
    endtask

    // offer one transaction, with a random gap before it, and hold until taken
    task automatic send_lag(input logic [31:0] ox, input logic [31:0] oy);
        while (!quiet_stretch && $urandom_range(99) < 6) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_offset_x <= ox; s_offset_y <= oy;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // wait until every expected result has come, then let the row empty
    task automatic drain;
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // random offset: mostly modest lags, sometimes any 32-bit value
    function automatic logic [31:0] rand_offset;
        case ($urandom_range(3))
            0: rand_offset = $urandom;
            1: rand_offset = $urandom_range(32'h0004_0000) - 32'h0002_0000;
            2: rand_offset = $urandom_range(32'h0000_1000) - 32'h0000_0800;
            default: rand_offset = $urandom_range(32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    initial begin
        logic [31:0] cfg_sets[6][3];
        cfg_sets = '{
            '{32'd13107, 32'd65536, 32'd113512},
            '{32'h8000_0000, 32'h7fff_ffff, 32'd1},
            '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff},
            '{32'd65536, 32'd65536, 32'd65536},
            '{32'hffff_0000, 32'h0010_0000, 32'd0},
            '{32'd0, 32'h7fff_ffff, 32'h0100_0000}
        };
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: zero lag, field extremes, huge exponent, tiny lag
        send_lag(0, 0);
        send_lag(32'h8000_0000, 32'h8000_0000);
        send_lag(32'h7fff_ffff, 32'h7fff_ffff);
        send_lag(32'h8000_0000, 0);
        send_lag(0, 32'h7fff_ffff);
        send_lag(1, 0);
        send_lag(32'hffff_ffff, 32'hffff_ffff);
        send_lag(32'h0001_0000, 32'hffff_0000);
        send_lag(32'h0000_5555, 32'haaaa_aaaa);
        send_lag(32'h0040_0000, 0);
        drain();

        // each setting: a few directed, then random; write the extremes too
        for (int c = 0; c < 6; c++) begin
            write_reg(expvar_pkg::REG_NUGGET, cfg_sets[c][0]);
            write_reg(expvar_pkg::REG_SILL, cfg_sets[c][1]);
            write_reg(expvar_pkg::REG_RANGE, cfg_sets[c][2]);
            send_lag(0, 0);
            send_lag(1, 1);
            send_lag(32'h8000_0000, 32'h7fff_ffff);
            for (int i = 0; i < 220; i++) begin
                quiet_stretch = (c == 2) && (i >= 40) && (i < 180);
                if (i == 100) begin
                    // hold off until the pipeline has nothing outstanding
                    s_valid <= 0;
                    @(posedge aclk);
                    while (pending_count != 0) @(posedge aclk);
                end
                send_lag(rand_offset(), rand_offset());
            end
            quiet_stretch = 0;
            drain();
        end

        if (error_count == 0) begin
            $display("exponential_variogram_eval_top test passed");
        end else begin
            $display("exponential_variogram_eval_top test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("exponential_variogram_eval_top test failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
sv/expvar_pkg.sv
sv/expvar_sqrt_cell.sv
sv/expvar_div_cell.sv
sv/expvar_series_cell.sv
sv/exponential_variogram_eval_top.sv
tb/exponential_variogram_eval_checker.sv
tb/exponential_variogram_eval_top_tb.sv
